// ----- design/cfae_pkg.sv -----
// Package for the chat format to ANSI escape unit: word types, command
// type passed from front to back, character constants and phase codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cfae_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_word_t;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_START      = 3'd1,
    PH_FG1        = 3'd2,
    PH_FG2        = 3'd3,
    PH_COMMA_FG   = 3'd4,
    PH_COMMA_NOFG = 3'd5,
    PH_BG1_FG     = 3'd6,
    PH_BG1_NOFG   = 3'd7
  } colour_phase_t;

  typedef enum logic [2:0] {
    SEG_PRE_FG  = 3'd0,
    SEG_PRE_BG  = 3'd1,
    SEG_ACT     = 3'd2,
    SEG_POST_FG = 3'd3,
    SEG_POST_BG = 3'd4,
    SEG_RST     = 3'd5
  } seg_t;

  localparam int unsigned SEG_N = 6;

  typedef enum logic {
    ACT_SGR   = 1'b0,
    ACT_PLAIN = 1'b1
  } act_t;

  typedef struct packed {
    logic [SEG_N-1:0] seg_en;
    act_t             act;
    logic [7:0]       act_byte;
    logic [6:0]       fore;
    logic [6:0]       back;
  } cmd_t;

  localparam logic [7:0] CODE_BOLD      = 8'h02;
  localparam logic [7:0] CODE_UNDERLINE = 8'h1F;
  localparam logic [7:0] CODE_REVERSE   = 8'h16;
  localparam logic [7:0] CODE_BLINK     = 8'h06;
  localparam logic [7:0] CODE_RESET     = 8'h0F;
  localparam logic [7:0] CODE_COLOUR    = 8'h03;

  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LBRKT  = 8'h5B;
  localparam logic [7:0] CH_M      = 8'h6D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_THREE  = 8'h33;
  localparam logic [7:0] CH_FOUR   = 8'h34;
  localparam logic [7:0] CH_FIVE   = 8'h35;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_EIGHT  = 8'h38;

endpackage

`default_nettype wire

// ----- design/cfae_front.sv -----
// Front end: accepts input words, runs the colour code phase machine and
// classifies each word into at most one command for the back end. Uses cfae_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfae_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  cfae_pkg::in_word_t  in_word,
  input  wire                 q_full,
  output logic                push_valid,
  output cfae_pkg::cmd_t      push_cmd
);

  cfae_pkg::colour_phase_t phase_r, phase_nxt;
  logic [6:0]  fore_r, fore_nxt;
  logic [6:0]  back_r, back_nxt;

  logic        accept;
  logic [7:0]  b;
  logic        digit;
  logic [3:0]  d;
  logic        taken;
  logic [10:0] fore10;
  logic [10:0] back10;
  cfae_pkg::colour_phase_t ph_mid;
  logic [cfae_pkg::SEG_N-1:0] en;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign b        = in_word.in_byte;
  assign digit    = (b >= cfae_pkg::CH_ZERO) && (b <= cfae_pkg::CH_NINE);
  assign d        = digit ? b[3:0] : 4'd0;
  assign fore10   = 11'({fore_r, 3'b000}) + 11'({fore_r, 1'b0}) + 11'(d);
  assign back10   = 11'({back_r, 3'b000}) + 11'({back_r, 1'b0}) + 11'(d);

  always_comb begin
    taken             = 1'b0;
    ph_mid            = phase_r;
    fore_nxt          = fore_r;
    back_nxt          = back_r;
    en                = '0;
    push_cmd.act      = cfae_pkg::ACT_PLAIN;
    push_cmd.act_byte = b;
    case (phase_r)
      cfae_pkg::PH_START: begin
        if (digit) begin
          fore_nxt = 7'(d);
          ph_mid   = cfae_pkg::PH_FG1;
          taken    = 1'b1;
        end else if (b == cfae_pkg::CH_COMMA) begin
          ph_mid = cfae_pkg::PH_COMMA_NOFG;
          taken  = 1'b1;
        end
      end
      cfae_pkg::PH_FG1: begin
        if (digit) begin
          fore_nxt = fore10[6:0];
          ph_mid   = cfae_pkg::PH_FG2;
          taken    = 1'b1;
        end else if (b == cfae_pkg::CH_COMMA) begin
          ph_mid = cfae_pkg::PH_COMMA_FG;
          taken  = 1'b1;
        end
      end
      cfae_pkg::PH_FG2: begin
        if (b == cfae_pkg::CH_COMMA) begin
          ph_mid = cfae_pkg::PH_COMMA_FG;
          taken  = 1'b1;
        end
      end
      cfae_pkg::PH_COMMA_FG: begin
        if (digit) begin
          back_nxt = 7'(d);
          ph_mid   = cfae_pkg::PH_BG1_FG;
          taken    = 1'b1;
        end
      end
      cfae_pkg::PH_COMMA_NOFG: begin
        if (digit) begin
          back_nxt = 7'(d);
          ph_mid   = cfae_pkg::PH_BG1_NOFG;
          taken    = 1'b1;
        end
      end
      cfae_pkg::PH_BG1_FG: begin
        if (digit) begin
          back_nxt                   = back10[6:0];
          en[cfae_pkg::SEG_PRE_FG]   = 1'b1;
          en[cfae_pkg::SEG_PRE_BG]   = 1'b1;
          ph_mid                     = cfae_pkg::PH_IDLE;
          taken                      = 1'b1;
        end
      end
      cfae_pkg::PH_BG1_NOFG: begin
        if (digit) begin
          back_nxt = back10[6:0];
          ph_mid   = cfae_pkg::PH_IDLE;
          taken    = 1'b1;
        end
      end
      default: begin
      end
    endcase

    push_cmd.fore = taken ? fore_nxt : fore_r;
    push_cmd.back = taken ? back_nxt : back_r;

    if (!taken) begin
      en[cfae_pkg::SEG_PRE_FG] = phase_r inside {cfae_pkg::PH_FG1, cfae_pkg::PH_FG2,
                                                 cfae_pkg::PH_COMMA_FG, cfae_pkg::PH_BG1_FG};
      en[cfae_pkg::SEG_PRE_BG] = (phase_r == cfae_pkg::PH_BG1_FG);
      ph_mid                   = cfae_pkg::PH_IDLE;
      en[cfae_pkg::SEG_ACT]    = 1'b1;
      push_cmd.act             = cfae_pkg::ACT_SGR;
      case (b)
        cfae_pkg::CODE_BOLD:      push_cmd.act_byte = cfae_pkg::CH_ONE;
        cfae_pkg::CODE_UNDERLINE: push_cmd.act_byte = cfae_pkg::CH_FOUR;
        cfae_pkg::CODE_REVERSE:   push_cmd.act_byte = cfae_pkg::CH_SEVEN;
        cfae_pkg::CODE_BLINK:     push_cmd.act_byte = cfae_pkg::CH_FIVE;
        cfae_pkg::CODE_RESET:     push_cmd.act_byte = cfae_pkg::CH_ZERO;
        cfae_pkg::CODE_COLOUR: begin
          en[cfae_pkg::SEG_ACT] = 1'b0;
          ph_mid                = cfae_pkg::PH_START;
          fore_nxt              = '0;
          back_nxt              = '0;
        end
        default: begin
          push_cmd.act      = cfae_pkg::ACT_PLAIN;
          push_cmd.act_byte = b;
        end
      endcase
    end

    phase_nxt = ph_mid;
    if (in_word.end_of_message) begin
      en[cfae_pkg::SEG_POST_FG] = ph_mid inside {cfae_pkg::PH_FG1, cfae_pkg::PH_FG2,
                                                 cfae_pkg::PH_COMMA_FG, cfae_pkg::PH_BG1_FG};
      en[cfae_pkg::SEG_POST_BG] = (ph_mid == cfae_pkg::PH_BG1_FG);
      en[cfae_pkg::SEG_RST]     = 1'b1;
      phase_nxt                 = cfae_pkg::PH_IDLE;
    end

    push_cmd.seg_en = en;
    push_valid      = accept && (en != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cfae_pkg::PH_IDLE;
      fore_r  <= '0;
      back_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      fore_r  <= fore_nxt;
      back_r  <= back_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/cfae_queue.sv -----
// Command queue between front and back end: register FIFO with a
// fall-through head. Uses cfae_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module cfae_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push,
  input  cfae_pkg::cmd_t  push_cmd,
  output logic            full,
  input  wire             pop,
  output logic            head_valid,
  output cfae_pkg::cmd_t  head_cmd
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cfae_pkg::cmd_t entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ----- design/cfae_back.sv -----
// Back end: expands the queue head command into output bytes, one per
// cycle unless the output stalls, into a registered output word. Uses cfae_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfae_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  head_valid,
  input  cfae_pkg::cmd_t       head_cmd,
  output logic                 pop,
  output logic                 out_valid,
  input  wire                  out_stall,
  output cfae_pkg::out_word_t  out_word
);

  function automatic logic [3:0] tens_of(input logic [6:0] v);
    logic [3:0] q;
    q = '0;
    for (int i = 1; i <= 12; i++) begin
      if (v >= 7'(i * 10)) q = 4'(i);
    end
    return q;
  endfunction

  logic [2:0] seg_r, seg_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  cfae_pkg::out_word_t out_word_r, out_word_nxt;

  cfae_pkg::seg_t cur;
  logic       found;
  logic       more;
  logic       emit;
  logic       seg_end;
  logic [7:0] byte_sel;
  logic       last_sel;
  logic [6:0] v;
  logic [7:0] lead;
  logic [3:0] q;
  logic [3:0] tens;
  logic [6:0] ones;
  logic       two;

  assign emit      = head_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    cur   = cfae_pkg::SEG_PRE_FG;
    found = 1'b0;
    for (int i = 0; i < cfae_pkg::SEG_N; i++) begin
      if (!found && (3'(i) >= seg_r) && head_cmd.seg_en[i]) begin
        cur   = cfae_pkg::seg_t'(3'(i));
        found = 1'b1;
      end
    end
    more = 1'b0;
    for (int j = 0; j < cfae_pkg::SEG_N; j++) begin
      if ((3'(j) > cur) && head_cmd.seg_en[j]) more = 1'b1;
    end
  end

  always_comb begin
    v    = (cur == cfae_pkg::SEG_PRE_BG || cur == cfae_pkg::SEG_POST_BG) ?
           head_cmd.back : head_cmd.fore;
    lead = (cur == cfae_pkg::SEG_PRE_BG || cur == cfae_pkg::SEG_POST_BG) ?
           cfae_pkg::CH_FOUR : cfae_pkg::CH_THREE;
    q    = tens_of(v);
    tens = (q >= 4'd10) ? q - 4'd10 : q;
    ones = v - (7'({q, 3'b000}) + 7'({q, 1'b0}));
    two  = (v >= 7'd10);

    byte_sel = cfae_pkg::CH_ESC;
    last_sel = 1'b0;
    seg_end  = 1'b0;
    case (cur)
      cfae_pkg::SEG_PRE_FG, cfae_pkg::SEG_PRE_BG,
      cfae_pkg::SEG_POST_FG, cfae_pkg::SEG_POST_BG: begin
        case (idx_r)
          4'd0:    byte_sel = cfae_pkg::CH_ESC;
          4'd1:    byte_sel = cfae_pkg::CH_LBRKT;
          4'd2:    byte_sel = lead;
          4'd3:    byte_sel = cfae_pkg::CH_EIGHT;
          4'd4:    byte_sel = cfae_pkg::CH_SEMI;
          4'd5:    byte_sel = cfae_pkg::CH_FIVE;
          4'd6:    byte_sel = cfae_pkg::CH_SEMI;
          4'd7:    byte_sel = cfae_pkg::CH_ZERO + (two ? 8'(tens) : 8'(ones));
          4'd8:    byte_sel = two ? cfae_pkg::CH_ZERO + 8'(ones) : cfae_pkg::CH_M;
          default: byte_sel = cfae_pkg::CH_M;
        endcase
        seg_end = (idx_r >= (two ? 4'd9 : 4'd8));
      end
      cfae_pkg::SEG_ACT: begin
        if (head_cmd.act == cfae_pkg::ACT_PLAIN) begin
          byte_sel = head_cmd.act_byte;
          seg_end  = 1'b1;
        end else begin
          case (idx_r)
            4'd0:    byte_sel = cfae_pkg::CH_ESC;
            4'd1:    byte_sel = cfae_pkg::CH_LBRKT;
            4'd2:    byte_sel = head_cmd.act_byte;
            default: byte_sel = cfae_pkg::CH_M;
          endcase
          seg_end = (idx_r >= 4'd3);
        end
      end
      default: begin
        case (idx_r)
          4'd0:    byte_sel = cfae_pkg::CH_ESC;
          4'd1:    byte_sel = cfae_pkg::CH_LBRKT;
          4'd2:    byte_sel = cfae_pkg::CH_ZERO;
          default: byte_sel = cfae_pkg::CH_M;
        endcase
        seg_end  = (idx_r >= 4'd3);
        last_sel = seg_end;
      end
    endcase
  end

  always_comb begin
    seg_nxt       = seg_r;
    idx_nxt       = idx_r;
    pop           = 1'b0;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    if (emit) begin
      out_valid_nxt         = 1'b1;
      out_word_nxt.out_byte = byte_sel;
      out_word_nxt.last     = last_sel;
      if (seg_end) begin
        idx_nxt = '0;
        if (more) begin
          seg_nxt = 3'(cur) + 3'd1;
        end else begin
          seg_nxt = '0;
          pop     = 1'b1;
        end
      end else begin
        idx_nxt = idx_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      seg_r       <= seg_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

endmodule

`default_nettype wire

// ----- design/chat_format_to_ansi_escape_unit.sv -----
// Top level of the chat format to ANSI escape unit: front end, command
// queue and back end. Uses cfae_pkg, cfae_front, cfae_queue, cfae_back.
//
//   channel  | ports                           | word
//   input    | in_valid, in_stall, in_word     | cfae_pkg::in_word_t
//   output   | out_valid, out_stall, out_word  | cfae_pkg::out_word_t
//
// Plain bytes go through at one word per cycle when no stall or escape expansion holds
// the flow; each is registered in the queue and again in the output word. An escape
// expands to 4 output bytes for SGR and 9 or 10 per colour. The back end emits one byte
// per cycle unless out_stall holds it; the queue fills while it expands. Input stalls
// only when the queue of QUEUE_DEPTH commands is full. Reset is synchronous and clears phase, queue and output valid.
`timescale 1ns / 1ps
`default_nettype none

module chat_format_to_ansi_escape_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  cfae_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  wire                  out_stall,
  output cfae_pkg::out_word_t  out_word
);

  logic           q_full;
  logic           push_valid;
  cfae_pkg::cmd_t push_cmd;
  logic           pop;
  logic           head_valid;
  cfae_pkg::cmd_t head_cmd;

  cfae_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_cmd   (push_cmd)
  );

  cfae_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  cfae_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

endmodule

`default_nettype wire

// ----- design/cfae_checker.sv -----
// Port checker for the chat format to ANSI escape unit, bound to the top
// level. Uses cfae_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfae_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_stall,
  input cfae_pkg::in_word_t   in_word,
  input wire                  out_valid,
  input wire                  out_stall,
  input cfae_pkg::out_word_t  out_word
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_word))
    else $error("stalled input word changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  a_out_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_in_reset: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

  a_last_is_m: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.last |-> out_word.out_byte == cfae_pkg::CH_M)
    else $error("last flag on a byte other than the closing m");

endmodule

bind chat_format_to_ansi_escape_unit cfae_checker u_cfae_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

`default_nettype wire

// ----- verif/chat_format_to_ansi_escape_unit_test.sv -----
// Self-checking bench for chat_format_to_ansi_escape_unit: a directed table, then random
// messages with colour sequences, checked against typed bytes or a built-in renderer.
// Depends on cfae_pkg and the unit RTL only.
`timescale 1ns / 1ps

module chat_format_to_ansi_escape_unit_test;

  localparam int unsigned MESSAGE_BYTES = 230;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned IDLE_LIMIT    = 2000;

  typedef struct packed {
    cfae_pkg::in_word_t word;
    logic [2:0]         n_typed;
    logic [39:0]        typed;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  cfae_pkg::in_word_t   in_word = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  cfae_pkg::out_word_t  out_word;

  stim_row_t               directed_rows [25];
  stim_row_t               message_script [$];
  cfae_pkg::out_word_t     byte_render [$];
  cfae_pkg::out_word_t     rendered_text [$];
  cfae_pkg::colour_phase_t colour_state;
  logic [6:0]              fore_num;
  logic [6:0]              back_num;
  int unsigned             bytes_taken;
  int unsigned             words_checked;
  int unsigned             mismatches;
  int unsigned             idle_cycles;
  int                      in_quiet;
  int                      out_quiet;

  chat_format_to_ansi_escape_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what);
    $display("mismatch at word %0d: %s", words_checked, what);
    mismatches++;
  endtask

  function automatic int draw_wait(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 11) == 0) quiet_left = $urandom_range(8, 30);
    return $urandom_range(0, 6);
  endfunction

  function automatic void emit(input logic [7:0] b, input logic is_last);
    cfae_pkg::out_word_t w;
    w.out_byte = b;
    w.last = is_last;
    byte_render.push_back(w);
  endfunction

  function automatic void emit_sgr(input logic [7:0] code, input logic is_last);
    emit(cfae_pkg::CH_ESC, 1'b0);
    emit(cfae_pkg::CH_LBRKT, 1'b0);
    emit(code, 1'b0);
    emit(cfae_pkg::CH_M, is_last);
  endfunction

  function automatic void emit_colour(input logic [7:0] lead, input logic [6:0] value);
    emit(cfae_pkg::CH_ESC, 1'b0);
    emit(cfae_pkg::CH_LBRKT, 1'b0);
    emit(lead, 1'b0);
    emit(cfae_pkg::CH_EIGHT, 1'b0);
    emit(cfae_pkg::CH_SEMI, 1'b0);
    emit(cfae_pkg::CH_FIVE, 1'b0);
    emit(cfae_pkg::CH_SEMI, 1'b0);
    if (value >= 7'd10) emit(cfae_pkg::CH_ZERO + 8'((value / 10) % 10), 1'b0);
    emit(cfae_pkg::CH_ZERO + 8'(value % 10), 1'b0);
    emit(cfae_pkg::CH_M, 1'b0);
  endfunction

  function automatic void close_colour();
    case (colour_state)
      cfae_pkg::PH_FG1, cfae_pkg::PH_FG2, cfae_pkg::PH_COMMA_FG:
        emit_colour(cfae_pkg::CH_THREE, fore_num);
      cfae_pkg::PH_BG1_FG: begin
        emit_colour(cfae_pkg::CH_THREE, fore_num);
        emit_colour(cfae_pkg::CH_FOUR, back_num);
      end
      default: ;
    endcase
    colour_state = cfae_pkg::PH_IDLE;
  endfunction

  function automatic void render_byte(input cfae_pkg::in_word_t w);
    logic [7:0] b;
    logic       is_digit;
    logic       is_comma;
    logic [6:0] d;
    logic       taken;
    b = w.in_byte;
    is_digit = (b >= cfae_pkg::CH_ZERO) && (b <= cfae_pkg::CH_NINE);
    is_comma = (b == cfae_pkg::CH_COMMA);
    d = is_digit ? 7'(b - cfae_pkg::CH_ZERO) : 7'd0;
    taken = 1'b0;
    case (colour_state)
      cfae_pkg::PH_START: begin
        if (is_digit) begin
          fore_num = d;
          colour_state = cfae_pkg::PH_FG1;
          taken = 1'b1;
        end else if (is_comma) begin
          colour_state = cfae_pkg::PH_COMMA_NOFG;
          taken = 1'b1;
        end
      end
      cfae_pkg::PH_FG1: begin
        if (is_digit) begin
          fore_num = 7'(fore_num * 10 + d);
          colour_state = cfae_pkg::PH_FG2;
          taken = 1'b1;
        end else if (is_comma) begin
          colour_state = cfae_pkg::PH_COMMA_FG;
          taken = 1'b1;
        end
      end
      cfae_pkg::PH_FG2: begin
        if (is_comma) begin
          colour_state = cfae_pkg::PH_COMMA_FG;
          taken = 1'b1;
        end
      end
      cfae_pkg::PH_COMMA_FG: begin
        if (is_digit) begin
          back_num = d;
          colour_state = cfae_pkg::PH_BG1_FG;
          taken = 1'b1;
        end
      end
      cfae_pkg::PH_COMMA_NOFG: begin
        if (is_digit) begin
          back_num = d;
          colour_state = cfae_pkg::PH_BG1_NOFG;
          taken = 1'b1;
        end
      end
      cfae_pkg::PH_BG1_FG: begin
        if (is_digit) begin
          back_num = 7'(back_num * 10 + d);
          close_colour();
          taken = 1'b1;
        end
      end
      cfae_pkg::PH_BG1_NOFG: begin
        if (is_digit) begin
          back_num = 7'(back_num * 10 + d);
          colour_state = cfae_pkg::PH_IDLE;
          taken = 1'b1;
        end
      end
      default: ;
    endcase
    if (!taken) begin
      close_colour();
      case (b)
        cfae_pkg::CODE_BOLD:      emit_sgr(cfae_pkg::CH_ONE, 1'b0);
        cfae_pkg::CODE_UNDERLINE: emit_sgr(cfae_pkg::CH_FOUR, 1'b0);
        cfae_pkg::CODE_REVERSE:   emit_sgr(cfae_pkg::CH_SEVEN, 1'b0);
        cfae_pkg::CODE_BLINK:     emit_sgr(cfae_pkg::CH_FIVE, 1'b0);
        cfae_pkg::CODE_RESET:     emit_sgr(cfae_pkg::CH_ZERO, 1'b0);
        cfae_pkg::CODE_COLOUR: begin
          colour_state = cfae_pkg::PH_START;
          fore_num = '0;
          back_num = '0;
        end
        default: emit(b, 1'b0);
      endcase
    end
    if (w.end_of_message) begin
      close_colour();
      emit_sgr(cfae_pkg::CH_ZERO, 1'b1);
    end
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    stim_row_t r;
    r = '0;
    r.word.in_byte = b;
    message_script.push_back(r);
  endfunction

  function automatic logic [7:0] any_digit();
    return cfae_pkg::CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic void add_random_messages();
    int unsigned pieces;
    int unsigned n;
    int unsigned i;
    int unsigned j;
    stim_row_t   tail;
    while (message_script.size() < MESSAGE_BYTES) begin
      pieces = $urandom_range(1, 8);
      for (i = 0; i < pieces; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: push_byte(8'($urandom_range(1, 255)));
          4: begin
            case ($urandom_range(0, 4))
              0: push_byte(cfae_pkg::CODE_BOLD);
              1: push_byte(cfae_pkg::CODE_UNDERLINE);
              2: push_byte(cfae_pkg::CODE_REVERSE);
              3: push_byte(cfae_pkg::CODE_BLINK);
              default: push_byte(cfae_pkg::CODE_RESET);
            endcase
          end
          9: begin
            case ($urandom_range(0, 2))
              0: push_byte(cfae_pkg::CH_COMMA);
              1: push_byte(any_digit());
              default: push_byte(cfae_pkg::CODE_COLOUR);
            endcase
          end
          default: begin
            push_byte(cfae_pkg::CODE_COLOUR);
            n = $urandom_range(0, 2);
            for (j = 0; j < n; j++) push_byte(any_digit());
            if ($urandom_range(0, 2) != 0) begin
              push_byte(cfae_pkg::CH_COMMA);
              n = $urandom_range(0, 2);
              for (j = 0; j < n; j++) push_byte(any_digit());
            end
          end
        endcase
      end
      tail = message_script.pop_back();
      tail.word.end_of_message = 1'b1;
      message_script.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin
    stim_row_t           row;
    cfae_pkg::out_word_t want;
    int unsigned         j;
    logic                moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_valid && !in_stall) begin
        row = message_script[bytes_taken];
        byte_render.delete();
        render_byte(in_word);
        if (row.n_typed != 0) begin
          for (j = 0; j < row.n_typed; j++) begin
            want.out_byte = row.typed[39 - 8 * j -: 8];
            want.last = row.word.end_of_message && (j == row.n_typed - 1);
            rendered_text.push_back(want);
          end
        end else begin
          foreach (byte_render[k]) rendered_text.push_back(byte_render[k]);
        end
        bytes_taken++;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (rendered_text.size() == 0) begin
          flag_mismatch($sformatf("unexpected word byte %h last %b",
                                  out_word.out_byte, out_word.last));
        end else begin
          want = rendered_text.pop_front();
          if (out_word.out_byte !== want.out_byte)
            flag_mismatch($sformatf("out_byte %h, want %h", out_word.out_byte, want.out_byte));
          if (out_word.last !== want.last)
            flag_mismatch($sformatf("last %b, want %b", out_word.last, want.last));
        end
        words_checked++;
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("chat_format_to_ansi_escape_unit regression: fail");
    $finish;
  end

  initial begin
    int gap;
    wait (rst_n);
    forever begin
      gap = draw_wait(out_quiet);
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    int gap;
    int unsigned i;
    colour_state = cfae_pkg::PH_IDLE;
    fore_num = '0;
    back_num = '0;
    directed_rows = '{
      '{'{8'h41, 1'b0}, 3'd1, {8'h41, 32'h0}},
      '{'{8'h01, 1'b0}, 3'd1, {8'h01, 32'h0}},
      '{'{8'hFF, 1'b1}, 3'd5,
        {8'hFF, cfae_pkg::CH_ESC, cfae_pkg::CH_LBRKT, cfae_pkg::CH_ZERO, cfae_pkg::CH_M}},
      '{'{cfae_pkg::CODE_BOLD, 1'b0}, 3'd4,
        {cfae_pkg::CH_ESC, cfae_pkg::CH_LBRKT, cfae_pkg::CH_ONE, cfae_pkg::CH_M, 8'h00}},
      '{'{cfae_pkg::CODE_UNDERLINE, 1'b0}, 3'd4,
        {cfae_pkg::CH_ESC, cfae_pkg::CH_LBRKT, cfae_pkg::CH_FOUR, cfae_pkg::CH_M, 8'h00}},
      '{'{cfae_pkg::CODE_REVERSE, 1'b0}, 3'd4,
        {cfae_pkg::CH_ESC, cfae_pkg::CH_LBRKT, cfae_pkg::CH_SEVEN, cfae_pkg::CH_M, 8'h00}},
      '{'{cfae_pkg::CODE_BLINK, 1'b0}, 3'd4,
        {cfae_pkg::CH_ESC, cfae_pkg::CH_LBRKT, cfae_pkg::CH_FIVE, cfae_pkg::CH_M, 8'h00}},
      '{'{cfae_pkg::CODE_RESET, 1'b0}, 3'd4,
        {cfae_pkg::CH_ESC, cfae_pkg::CH_LBRKT, cfae_pkg::CH_ZERO, cfae_pkg::CH_M, 8'h00}},
      '{'{cfae_pkg::CODE_COLOUR, 1'b0}, 3'd0, 40'h0},
      '{'{cfae_pkg::CH_NINE, 1'b0}, 3'd0, 40'h0},
      '{'{cfae_pkg::CH_NINE, 1'b0}, 3'd0, 40'h0},
      '{'{cfae_pkg::CH_COMMA, 1'b0}, 3'd0, 40'h0},
      '{'{cfae_pkg::CH_NINE, 1'b0}, 3'd0, 40'h0},
      '{'{cfae_pkg::CH_NINE, 1'b0}, 3'd0, 40'h0},
      '{'{cfae_pkg::CODE_COLOUR, 1'b0}, 3'd0, 40'h0},
      '{'{cfae_pkg::CH_COMMA, 1'b0}, 3'd0, 40'h0},
      '{'{cfae_pkg::CH_FIVE, 1'b0}, 3'd0, 40'h0},
      '{'{cfae_pkg::CH_FIVE, 1'b0}, 3'd0, 40'h0},
      '{'{cfae_pkg::CODE_COLOUR, 1'b0}, 3'd0, 40'h0},
      '{'{cfae_pkg::CH_ZERO, 1'b0}, 3'd0, 40'h0},
      '{'{cfae_pkg::CH_SEVEN, 1'b0}, 3'd0, 40'h0},
      '{'{cfae_pkg::CH_COMMA, 1'b0}, 3'd0, 40'h0},
      '{'{cfae_pkg::CH_FOUR, 1'b0}, 3'd0, 40'h0},
      '{'{cfae_pkg::CODE_UNDERLINE, 1'b0}, 3'd0, 40'h0},
      '{'{cfae_pkg::CODE_COLOUR, 1'b1}, 3'd4,
        {cfae_pkg::CH_ESC, cfae_pkg::CH_LBRKT, cfae_pkg::CH_ZERO, cfae_pkg::CH_M, 8'h00}}
    };
    foreach (directed_rows[k]) message_script.push_back(directed_rows[k]);
    add_random_messages();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (i = 0; i < message_script.size(); i++) begin
      gap = draw_wait(in_quiet);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_word <= message_script[i].word;
      // hold the word until taken
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    in_valid <= 1'b0;

    while (bytes_taken != message_script.size() || rendered_text.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("chat_format_to_ansi_escape_unit regression: pass");
    else
      $display("chat_format_to_ansi_escape_unit regression: fail");
    $finish;
  end

endmodule

// ----- chat_format_to_ansi_escape_unit.f -----
design/cfae_pkg.sv
design/cfae_front.sv
design/cfae_queue.sv
design/cfae_back.sv
design/chat_format_to_ansi_escape_unit.sv
design/cfae_checker.sv
verif/chat_format_to_ansi_escape_unit_test.sv
